// ----- hw/rtl/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg: force/torque calibration shared definitions
// Widths, register map, beat payloads, lane control and the coefficient ROM.
// ----------------------------------------------------------------------------
package fsc_pkg;

	localparam int NUM_AXES             = 6;
	localparam int SAMPLE_WIDTH_DEF     = 32;
	localparam int COEF_FRAC_BITS_DEF   = 8;
	localparam int FIELD_W              = 32;
	localparam int DIFF_W               = 33;
	localparam int ROM_W                = 25;
	localparam int ROM_FRAC             = 8;
	localparam int ROM_DEPTH            = 36;
	localparam int ROM_AW               = 6;
	localparam int TAP_W                = 3;
	localparam int GAIN_W               = 32;
	localparam int ADDR_W               = 5;
	localparam int DATA_W               = 32;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd85319175;

	typedef enum logic [2:0] {
		REG_OFFSET_CH0 = 3'd0,
		REG_OFFSET_CH1 = 3'd1,
		REG_OFFSET_CH2 = 3'd2,
		REG_OFFSET_CH3 = 3'd3,
		REG_OFFSET_CH4 = 3'd4,
		REG_OFFSET_CH5 = 3'd5,
		REG_GAIN_SCALE = 3'd6
	} fsc_reg_t;

	typedef struct packed {
		logic                      sensor_side;
		logic signed [FIELD_W-1:0] raw_0;
		logic signed [FIELD_W-1:0] raw_1;
		logic signed [FIELD_W-1:0] raw_2;
		logic signed [FIELD_W-1:0] raw_3;
		logic signed [FIELD_W-1:0] raw_4;
		logic signed [FIELD_W-1:0] raw_5;
	} fsc_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] axis_out_0;
		logic signed [FIELD_W-1:0] axis_out_1;
		logic signed [FIELD_W-1:0] axis_out_2;
		logic signed [FIELD_W-1:0] axis_out_3;
		logic signed [FIELD_W-1:0] axis_out_4;
		logic signed [FIELD_W-1:0] axis_out_5;
		logic                      clipped;
	} fsc_out_t;

	typedef struct packed {
		logic             mac_en;
		logic             issue;
		logic             side;
		logic [TAP_W-1:0] tap;
		logic             acc_en;
		logic             acc_first;
		logic             acc_last;
		logic             ld_s4;
		logic             ld_s5;
		logic             ld_s6;
	} fsc_lane_ctl_t;

	// accumulator width: product of difference and coefficient, plus six-term growth
	function automatic int acc_width(input int frac);
		return DIFF_W + ROM_W + frac - ROM_FRAC + 3;
	endfunction

	// width of the scaled magnitude after the final shift
	function automatic int q_width(input int frac);
		return acc_width(frac) + 1 - frac;
	endfunction

	// row-major calibration matrices, 8 fraction bits; [side][row*6+col]
	localparam logic signed [ROM_W-1:0] COEF_ROM [2][ROM_DEPTH] = '{
		'{
			-25'sd202049,  25'sd28290,    25'sd412563,  -25'sd5810932, -25'sd177802,  25'sd5759936,
			-25'sd311970,  25'sd6820267, -25'sd179888,  -25'sd3340269,  25'sd365664, -25'sd3329266,
			 25'sd8462152, 25'sd303927,   25'sd8292314,  25'sd269394,   25'sd8589797, 25'sd332199,
			-25'sd470,     25'sd48116,   -25'sd137665,  -25'sd29204,    25'sd138122, -25'sd16917,
			 25'sd156303,  25'sd6234,    -25'sd82428,    25'sd37810,   -25'sd76365,  -25'sd43877,
			 25'sd6471,   -25'sd86623,    25'sd2477,    -25'sd83301,    25'sd1536,   -25'sd84853
		},
		'{
			-25'sd72489,   25'sd18747,    25'sd379350,  -25'sd5722882, -25'sd214703,  25'sd5744182,
			-25'sd711638,  25'sd6533067,  25'sd46983,   -25'sd3349172,  25'sd357658, -25'sd3327892,
			 25'sd8010184, 25'sd395611,   25'sd8367839,  25'sd407546,   25'sd8453207, 25'sd711903,
			-25'sd5260,    25'sd43903,   -25'sd133434,  -25'sd28803,    25'sd136186, -25'sd11572,
			 25'sd151222,  25'sd6149,    -25'sd82969,    25'sd34644,   -25'sd76295,  -25'sd44287,
			 25'sd9192,   -25'sd82006,    25'sd4921,    -25'sd84021,    25'sd2250,   -25'sd85589
		}
	};

endpackage

// ----- hw/rtl/fsc_stream_if.sv -----
// ----------------------------------------------------------------------------
// fsc_stream_if: valid/ready stream channel
// Carries one payload beat per valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/fsc_lane.sv -----
// ----------------------------------------------------------------------------
// fsc_lane: one calibration matrix row
// Multiply-accumulate over six taps, then sign/magnitude, gain product and
// rounding shift.
// ----------------------------------------------------------------------------
module fsc_lane #(
	parameter int COEF_FRAC_BITS = fsc_pkg::COEF_FRAC_BITS_DEF,
	parameter int LANE           = 0
) (
	input  logic                                                   clk,
	input  fsc_pkg::fsc_lane_ctl_t                                 ctl,
	input  logic signed [fsc_pkg::DIFF_W-1:0]                      dop,
	input  logic [fsc_pkg::GAIN_W-1:0]                             gain,
	output logic [fsc_pkg::q_width(COEF_FRAC_BITS)-1:0]            q_s6,
	output logic                                                   neg_s6
);

	localparam int CW  = fsc_pkg::ROM_W + COEF_FRAC_BITS - fsc_pkg::ROM_FRAC;
	localparam int PW  = fsc_pkg::DIFF_W + CW;
	localparam int AW  = fsc_pkg::acc_width(COEF_FRAC_BITS);
	localparam int LW  = (AW + 1) / 2;
	localparam int HW  = AW - LW;
	localparam int PLW = LW + fsc_pkg::GAIN_W;
	localparam int PHW = HW + fsc_pkg::GAIN_W;
	localparam int SH  = 32 + COEF_FRAC_BITS;
	localparam int NW  = AW + 33;
	localparam logic [fsc_pkg::ROM_AW-1:0] ROW_BASE = fsc_pkg::ROM_AW'(LANE * fsc_pkg::NUM_AXES);

	logic [fsc_pkg::ROM_AW-1:0]       rom_addr;
	logic signed [fsc_pkg::ROM_W-1:0] rom_c;
	logic signed [CW-1:0]             coef_c;

	logic signed [CW-1:0]             coef_s1;
	logic signed [fsc_pkg::DIFF_W-1:0] dop_s1;
	logic signed [PW-1:0]             prod_s2;
	logic signed [AW-1:0]             acc_q;
	logic signed [AW-1:0]             acc_base;
	logic signed [AW-1:0]             tot;
	logic signed [AW-1:0]             sum_s3;
	logic [AW-1:0]                    mag_s4;
	logic                             neg_s4;
	logic [PLW-1:0]                   plo_s5;
	logic [PHW-1:0]                   phi_s5;
	logic                             neg_s5;
	logic [NW-1:0]                    rnd;

	assign rom_addr = ROW_BASE + fsc_pkg::ROM_AW'(ctl.tap);
	assign rom_c    = fsc_pkg::COEF_ROM[ctl.side][rom_addr];

	generate
		if (COEF_FRAC_BITS >= fsc_pkg::ROM_FRAC) begin : g_up
			assign coef_c = CW'(rom_c) <<< (COEF_FRAC_BITS - fsc_pkg::ROM_FRAC);
		end else begin : g_dn
			localparam int DN = fsc_pkg::ROM_FRAC - COEF_FRAC_BITS;
			logic [fsc_pkg::ROM_W-1:0] mag;
			logic [fsc_pkg::ROM_W-1:0] mag_r;
			logic signed [CW-1:0]      cm;
			// magnitude rounded half away from zero
			assign mag    = rom_c[fsc_pkg::ROM_W-1] ? fsc_pkg::ROM_W'(-rom_c) : rom_c;
			assign mag_r  = (mag + (fsc_pkg::ROM_W'(1) << (DN - 1))) >> DN;
			assign cm     = $signed(mag_r[CW-1:0]);
			assign coef_c = rom_c[fsc_pkg::ROM_W-1] ? -cm : cm;
		end
	endgenerate

	assign acc_base = ctl.acc_first ? '0 : acc_q;
	assign tot      = acc_base + AW'(prod_s2);
	assign rnd      = NW'({phi_s5, {LW{1'b0}}}) + NW'(plo_s5) + (NW'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			coef_s1 <= coef_c;
			dop_s1  <= dop;
		end
		if (ctl.mac_en) begin
			prod_s2 <= PW'(coef_s1) * PW'(dop_s1);
		end
		if (ctl.acc_en) begin
			if (ctl.acc_last) begin
				sum_s3 <= tot;
			end else begin
				acc_q <= tot;
			end
		end
		if (ctl.ld_s4) begin
			neg_s4 <= sum_s3[AW-1];
			mag_s4 <= sum_s3[AW-1] ? AW'(-sum_s3) : sum_s3;
		end
		if (ctl.ld_s5) begin
			plo_s5 <= PLW'(mag_s4[LW-1:0]) * PLW'(gain);
			phi_s5 <= PHW'(mag_s4[AW-1:LW]) * PHW'(gain);
			neg_s5 <= neg_s4;
		end
		if (ctl.ld_s6) begin
			q_s6   <= rnd[NW-1:SH];
			neg_s6 <= neg_s5;
		end
	end

endmodule

// ----- hw/rtl/fsc_merge.sv -----
// ----------------------------------------------------------------------------
// fsc_merge: lane merge and output register
// Saturates each lane to signed 32 bits, ORs the clip flags, holds the beat.
// ----------------------------------------------------------------------------
module fsc_merge #(
	parameter int COEF_FRAC_BITS = fsc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        ld,
	input  logic [fsc_pkg::q_width(COEF_FRAC_BITS)-1:0] q [fsc_pkg::NUM_AXES],
	input  logic [fsc_pkg::NUM_AXES-1:0]                neg,
	output fsc_pkg::fsc_out_t                           out_q
);

	localparam int QW = fsc_pkg::q_width(COEF_FRAC_BITS);
	localparam logic [QW-1:0] POS_LIM = QW'(32'h7FFF_FFFF);
	localparam logic [QW-1:0] NEG_LIM = QW'(32'h8000_0000);

	logic [fsc_pkg::FIELD_W-1:0] res [fsc_pkg::NUM_AXES];
	logic [fsc_pkg::NUM_AXES-1:0] sat;

	always_comb begin
		for (int i = 0; i < fsc_pkg::NUM_AXES; i++) begin
			sat[i] = neg[i] ? (q[i] > NEG_LIM) : (q[i] > POS_LIM);
			if (sat[i]) begin
				res[i] = neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				res[i] = neg[i] ? -q[i][fsc_pkg::FIELD_W-1:0] : q[i][fsc_pkg::FIELD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q.axis_out_0 <= res[0];
			out_q.axis_out_1 <= res[1];
			out_q.axis_out_2 <= res[2];
			out_q.axis_out_3 <= res[3];
			out_q.axis_out_4 <= res[4];
			out_q.axis_out_5 <= res[5];
			out_q.clipped    <= |sat;
		end
	end

endmodule

// ----- hw/rtl/force_torque_calibration_core.sv -----
// ----------------------------------------------------------------------------
// force_torque_calibration_core: six-axis force/torque calibration
// Offset removal, 6x6 calibration matrix, reciprocal gain, Q16 saturation.
// ----------------------------------------------------------------------------
// Usage:
//   gauge  (sink)   : one beat = sensor side select and six raw gauge samples.
//   wrench (source) : one beat = six signed Q16 axes and a clip flag, one
//                     wrench beat for every gauge beat, in order.
//   APB port        : offsets ch0..ch5 at 0x00..0x14, gain_scale at 0x18;
//                     write only while no beat is in flight.
// Issue: six lanes each walk their matrix row one tap per cycle while the MAC
//   stage is not frozen, through a shared operand select, so the tap count sets
//   the interval; the next beat is taken on the cycle its last tap issues.
// Path: gauge handshake to wrench valid runs through input capture, the tap walk,
//   operand, product and accumulate registers, sign/magnitude, gain product, rounding, merge.
// Reset: pipeline empty, offsets 0, gain_scale 85319175.
// Stall: a held wrench beat fills the scale stages behind it; once the
//   finished row sums cannot move on, the MAC stage freezes and gauge.ready
//   drops. No beat is lost or repeated.
// ----------------------------------------------------------------------------
module force_torque_calibration_core #(
	parameter int SAMPLE_WIDTH   = fsc_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = fsc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [fsc_pkg::DATA_W-1:0]   pwdata,
	output logic [fsc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	fsc_stream_if.sink                   gauge,
	fsc_stream_if.source                 wrench
);

	localparam int QW = fsc_pkg::q_width(COEF_FRAC_BITS);
	localparam logic [fsc_pkg::TAP_W-1:0] LAST_TAP = fsc_pkg::TAP_W'(fsc_pkg::NUM_AXES - 1);

	// configuration
	logic [fsc_pkg::DATA_W-1:0] offset_q [fsc_pkg::NUM_AXES];
	logic [fsc_pkg::GAIN_W-1:0] gain_q;
	fsc_pkg::fsc_reg_t          reg_idx;
	logic                       cfg_wr;

	// input capture
	fsc_pkg::fsc_in_t                   in_beat;
	logic signed [fsc_pkg::FIELD_W-1:0] raw [fsc_pkg::NUM_AXES];
	logic signed [fsc_pkg::DIFF_W-1:0]  diff [fsc_pkg::NUM_AXES];
	logic signed [fsc_pkg::DIFF_W-1:0]  diff_q [fsc_pkg::NUM_AXES];
	logic                               side_q;
	logic                               iss_q;
	logic [fsc_pkg::TAP_W-1:0]          cnt_q;
	logic                               in_acc;

	// pipeline valids
	logic v_s1, first_s1, last_s1;
	logic v_s2, first_s2, last_s2;
	logic v_s3, v_s4, v_s5, v_s6, v_o;
	logic rdy_4, rdy_5, rdy_6, rdy_o;
	logic mac_en, issue;

	fsc_pkg::fsc_lane_ctl_t     ctl;
	logic [QW-1:0]              lane_q [fsc_pkg::NUM_AXES];
	logic [fsc_pkg::NUM_AXES-1:0] lane_neg;
	fsc_pkg::fsc_out_t          out_q;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign reg_idx = fsc_pkg::fsc_reg_t'(paddr[fsc_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			fsc_pkg::REG_OFFSET_CH0, fsc_pkg::REG_OFFSET_CH1, fsc_pkg::REG_OFFSET_CH2,
			fsc_pkg::REG_OFFSET_CH3, fsc_pkg::REG_OFFSET_CH4, fsc_pkg::REG_OFFSET_CH5: begin
				prdata = offset_q[reg_idx];
			end
			fsc_pkg::REG_GAIN_SCALE: begin
				prdata = gain_q;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsc_pkg::NUM_AXES; i++) begin
				offset_q[i] <= '0;
			end
			gain_q <= fsc_pkg::GAIN_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				fsc_pkg::REG_OFFSET_CH0, fsc_pkg::REG_OFFSET_CH1, fsc_pkg::REG_OFFSET_CH2,
				fsc_pkg::REG_OFFSET_CH3, fsc_pkg::REG_OFFSET_CH4, fsc_pkg::REG_OFFSET_CH5: begin
					offset_q[reg_idx] <= pwdata;
				end
				fsc_pkg::REG_GAIN_SCALE: begin
					gain_q <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- input and offset removal ----------------
	assign in_beat = gauge.payload;
	assign raw[0]  = in_beat.raw_0;
	assign raw[1]  = in_beat.raw_1;
	assign raw[2]  = in_beat.raw_2;
	assign raw[3]  = in_beat.raw_3;
	assign raw[4]  = in_beat.raw_4;
	assign raw[5]  = in_beat.raw_5;

	always_comb begin
		for (int j = 0; j < fsc_pkg::NUM_AXES; j++) begin
			diff[j] = fsc_pkg::DIFF_W'($signed(raw[j][SAMPLE_WIDTH-1:0]))
				- fsc_pkg::DIFF_W'($signed(offset_q[j]));
		end
	end

	// ---------------- handshake and pipeline control ----------------
	assign rdy_o  = !v_o || wrench.ready;
	assign rdy_6  = !v_s6 || rdy_o;
	assign rdy_5  = !v_s5 || rdy_6;
	assign rdy_4  = !v_s4 || rdy_5;
	// freeze MAC when a finished row sum has nowhere to go
	assign mac_en = !(v_s2 && last_s2 && v_s3 && !rdy_4);
	assign issue  = iss_q && mac_en;

	assign gauge.ready = mac_en && (!iss_q || (cnt_q == LAST_TAP));
	assign in_acc      = gauge.valid && gauge.ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			diff_q <= diff;
			side_q <= in_beat.sensor_side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= 1'b0;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_o      <= 1'b0;
		end else begin
			if (in_acc) begin
				iss_q <= 1'b1;
				cnt_q <= '0;
			end else if (issue) begin
				if (cnt_q == LAST_TAP) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (mac_en) begin
				v_s1     <= issue;
				first_s1 <= (cnt_q == '0);
				last_s1  <= (cnt_q == LAST_TAP);
				v_s2     <= v_s1;
				first_s2 <= first_s1;
				last_s2  <= last_s1;
			end
			if (mac_en && v_s2 && last_s2) begin
				v_s3 <= 1'b1;
			end else if (rdy_4) begin
				v_s3 <= 1'b0;
			end
			if (rdy_4) begin
				v_s4 <= v_s3;
			end
			if (rdy_5) begin
				v_s5 <= v_s4;
			end
			if (rdy_6) begin
				v_s6 <= v_s5;
			end
			if (rdy_o) begin
				v_o <= v_s6;
			end
		end
	end

	always_comb begin
		ctl.mac_en    = mac_en;
		ctl.issue     = issue;
		ctl.side      = side_q;
		ctl.tap       = cnt_q;
		ctl.acc_en    = mac_en && v_s2;
		ctl.acc_first = first_s2;
		ctl.acc_last  = last_s2;
		ctl.ld_s4     = rdy_4 && v_s3;
		ctl.ld_s5     = rdy_5 && v_s4;
		ctl.ld_s6     = rdy_6 && v_s5;
	end

	// ---------------- lanes ----------------
	for (genvar g = 0; g < fsc_pkg::NUM_AXES; g++) begin : g_lane
		fsc_lane #(
			.COEF_FRAC_BITS (COEF_FRAC_BITS),
			.LANE           (g)
		) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.dop    (diff_q[cnt_q]),
			.gain   (gain_q),
			.q_s6   (lane_q[g]),
			.neg_s6 (lane_neg[g])
		);
	end

	fsc_merge #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_merge (
		.clk   (clk),
		.ld    (rdy_o && v_s6),
		.q     (lane_q),
		.neg   (lane_neg),
		.out_q (out_q)
	);

	assign wrench.valid   = v_o;
	assign wrench.payload = out_q;

endmodule
